### hw/rtl/lpd_pkg.sv
package lpd_pkg;

   localparam int unsigned EnableWidth = 32;

   localparam logic [7:0] StartByteReset = 8'd126;

   localparam logic CsrStartByte     = 1'b0;
   localparam logic CsrChannelEnable = 1'b1;

   localparam logic KindPayload = 1'b0;
   localparam logic KindReport  = 1'b1;

   localparam logic [1:0] StatusOk       = 2'd0;
   localparam logic [1:0] StatusChecksum = 2'd1;
   localparam logic [1:0] StatusUnmapped = 2'd2;
   localparam logic [1:0] StatusTimeout  = 2'd3;

   localparam logic ActionByte    = 1'b0;
   localparam logic ActionTimeout = 1'b1;

   typedef struct packed {
      logic       action;
      logic [7:0] rx_byte;
   } lpd_item_type;

   typedef struct packed {
      logic       kind;
      logic [4:0] channel;
      logic [7:0] payload_byte;
      logic [1:0] status;
   } lpd_result_type;

endpackage

### hw/rtl/link_packet_deframer.sv
// Byte-link packet deframer.
// req_ channel: one beat per received byte (tuser low) or receive timeout
// (tuser high). Bytes are dropped until the start byte, then a metadata byte,
// a little-endian size, the payload and a little-endian checksum follow.
// rsp_ channel: tuser low carries a payload byte of an enabled channel;
// tuser high is the end-of-packet report with its status (ok, checksum
// mismatch, unmapped channel, timeout).
// csr_ port: index 0 start byte, index 1 channel enable bitmap; write only
// while idle.
// Each beat passes from the input register through the parser into the result register, which drives rsp_.
// Throughput: one beat per cycle while rsp_ does not stall; every byte needs one add and compare in the
// parser between the input register and the result register.
// Reset empties both registers, returns to hunting, sets the start byte to
// 126 and disables all channels.
// When rsp_tready is low the result register holds and the input register
// takes one more beat, then req_tready drops until the result is taken.
module link_packet_deframer #(
   parameter int unsigned CHANNEL_COUNT = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // channel, payload_byte, status, pad
   output logic        rsp_tuser,   // kind
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [lpd_pkg::EnableWidth-1:0] csr_wdata
);
   import lpd_pkg::*;

   logic [7:0]               start_byte_ff;
   logic [CHANNEL_COUNT-1:0] chan_en_ff;
   logic [EnableWidth-1:0]   enable_map;

   logic         in_valid_ff;
   lpd_item_type in_item_ff;

   logic           out_ready;
   logic           advance;
   logic           res_valid;
   lpd_result_type res;

   assign enable_map = EnableWidth'(chan_en_ff);
   assign advance    = in_valid_ff && out_ready;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= StartByteReset;
         chan_en_ff    <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CsrStartByte:     start_byte_ff <= csr_wdata[7:0];
            CsrChannelEnable: chan_en_ff    <= csr_wdata[CHANNEL_COUNT-1:0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= '{action: req_tuser, rx_byte: req_tdata};
      end
   end

   lpd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .item       (in_item_ff),
      .start_byte (start_byte_ff),
      .enable_map (enable_map),
      .res_valid  (res_valid),
      .res        (res)
   );

   lpd_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (res_valid),
      .res        (res),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### hw/rtl/lpd_parser.sv
module lpd_parser (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  lpd_pkg::lpd_item_type            item,
   input  logic [7:0]                       start_byte,
   input  logic [lpd_pkg::EnableWidth-1:0]  enable_map,
   output logic                             res_valid,
   output lpd_pkg::lpd_result_type          res
);
   import lpd_pkg::*;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_META    = 3'd1,
      PH_SIZE_LO = 3'd2,
      PH_SIZE_HI = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CHK_LO  = 3'd5,
      PH_CHK_HI  = 3'd6
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  meta_ff, meta_in;
   logic [7:0]  size_lo_ff, size_lo_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  check_low_ff, check_low_in;

   logic [4:0]  chan;
   logic        chan_on;
   logic [15:0] size_full;
   logic [15:0] got_check;
   logic        is_timeout;
   logic [7:0]  b;

   assign chan       = meta_ff[4:0];
   assign chan_on    = enable_map[chan];
   assign b          = item.rx_byte;
   assign is_timeout = (item.action == ActionTimeout);
   assign size_full  = {b, size_lo_ff};
   assign got_check  = {b, check_low_ff};

   always_comb begin
      phase_in     = phase_ff;
      meta_in      = meta_ff;
      size_lo_in   = size_lo_ff;
      remaining_in = remaining_ff;
      sum_in       = sum_ff;
      check_low_in = check_low_ff;
      res_valid    = 1'b0;
      res          = '{kind: KindReport, channel: chan, payload_byte: 8'd0,
                       status: StatusTimeout};
      case (phase_ff)
         PH_META, PH_SIZE_LO, PH_SIZE_HI, PH_PAYLOAD, PH_CHK_LO, PH_CHK_HI: begin
            if (is_timeout) begin
               res_valid = 1'b1;
               phase_in  = PH_HUNT;
            end else begin
               case (phase_ff)
                  PH_META: begin
                     meta_in  = b;
                     sum_in   = {8'd0, b};
                     phase_in = PH_SIZE_LO;
                  end
                  PH_SIZE_LO: begin
                     size_lo_in = b;
                     sum_in     = sum_ff + {8'd0, b};
                     phase_in   = PH_SIZE_HI;
                  end
                  PH_SIZE_HI: begin
                     sum_in       = sum_ff + {b, 8'd0};
                     remaining_in = size_full;
                     phase_in     = (size_full == 16'd0) ? PH_CHK_LO : PH_PAYLOAD;
                  end
                  PH_PAYLOAD: begin
                     sum_in       = sum_ff + {8'd0, b};
                     remaining_in = remaining_ff - 16'd1;
                     if (remaining_ff == 16'd1) begin
                        phase_in = PH_CHK_LO;
                     end
                     res_valid = chan_on;
                     res = '{kind: KindPayload, channel: chan, payload_byte: b,
                             status: StatusOk};
                  end
                  PH_CHK_LO: begin
                     check_low_in = b;
                     phase_in     = PH_CHK_HI;
                  end
                  default: begin
                     res_valid = 1'b1;
                     if (got_check != ~sum_ff) begin
                        res.status = StatusChecksum;
                     end else if (!chan_on) begin
                        res.status = StatusUnmapped;
                     end else begin
                        res.status = StatusOk;
                     end
                     phase_in = PH_HUNT;
                  end
               endcase
            end
         end
         default: begin
            phase_in = PH_HUNT;
            if (!is_timeout && b == start_byte) begin
               phase_in = PH_META;
               meta_in  = 8'd0;
            end
         end
      endcase
      if (!step) begin
         res_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         meta_ff  <= 8'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         meta_ff  <= meta_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         size_lo_ff   <= size_lo_in;
         remaining_ff <= remaining_in;
         sum_ff       <= sum_in;
         check_low_ff <= check_low_in;
      end
   end

endmodule

### hw/rtl/lpd_out_reg.sv
module lpd_out_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  lpd_pkg::lpd_result_type res,
   output logic                    out_ready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [15:0]             rsp_tdata,  // channel, payload_byte, status, pad
   output logic                    rsp_tuser   // kind
);
   import lpd_pkg::*;

   logic           valid_ff;
   lpd_result_type data_ff;

   assign out_ready  = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = data_ff.kind;
   assign rsp_tdata  = {1'b0, data_ff.status, data_ff.payload_byte, data_ff.channel};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

endmodule

### bench/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lpd_pkg::*;

   localparam int ChannelCount = 32;
   localparam int StallLimit = 1500;
   localparam int PhaseBeats = 128;

   typedef enum logic [2:0] {
      StepHunt, StepMeta, StepSizeLo, StepSizeHi, StepPayload, StepCheckLo, StepCheckHi
   } parse_step_type;

   class frame_tracker;
      logic [7:0]     start_value;
      logic [31:0]    enable_mask;
      parse_step_type step;
      logic [7:0]     meta;
      logic [15:0]    frame_size;
      logic [15:0]    bytes_left;
      logic [15:0]    frame_sum;
      logic [7:0]     check_lo;
      lpd_result_type expected_results[$];
      int unsigned    errors;

      function new();
         start_value = StartByteReset;
         enable_mask = '0;
         step = StepHunt;
         meta = '0;
         frame_size = '0;
         bytes_left = '0;
         frame_sum = '0;
         check_lo = '0;
         errors = 0;
      endfunction

      function bit channel_on(logic [4:0] ch);
         return (int'(ch) < ChannelCount) && enable_mask[ch];
      endfunction

      function void absorb_beat(logic act, logic [7:0] b);
         lpd_result_type res;
         res = '0;
         res.channel = meta[4:0];
         if (step == StepHunt) begin
            if (act == ActionByte && b == start_value) begin
               step = StepMeta;
               meta = '0;
               frame_size = '0;
               bytes_left = '0;
               frame_sum = '0;
               check_lo = '0;
            end
            return;
         end
         if (act == ActionTimeout) begin
            res.kind = KindReport;
            res.status = StatusTimeout;
            expected_results.push_back(res);
            step = StepHunt;
            return;
         end
         case (step)
            StepMeta: begin
               meta = b;
               frame_sum = {8'h00, b};
               step = StepSizeLo;
            end
            StepSizeLo: begin
               frame_size = {8'h00, b};
               frame_sum = frame_sum + {8'h00, b};
               step = StepSizeHi;
            end
            StepSizeHi: begin
               frame_size[15:8] = b;
               frame_sum = frame_sum + {b, 8'h00};
               bytes_left = frame_size;
               step = (frame_size == 16'd0) ? StepCheckLo : StepPayload;
            end
            StepPayload: begin
               frame_sum = frame_sum + {8'h00, b};
               bytes_left = bytes_left - 16'd1;
               if (bytes_left == 16'd0) step = StepCheckLo;
               if (channel_on(meta[4:0])) begin
                  res.kind = KindPayload;
                  res.payload_byte = b;
                  res.status = StatusOk;
                  expected_results.push_back(res);
               end
            end
            StepCheckLo: begin
               check_lo = b;
               step = StepCheckHi;
            end
            default: begin
               res.kind = KindReport;
               if ({b, check_lo} != ~frame_sum) res.status = StatusChecksum;
               else if (!channel_on(meta[4:0])) res.status = StatusUnmapped;
               else res.status = StatusOk;
               expected_results.push_back(res);
               step = StepHunt;
            end
         endcase
      endfunction

      function void check_result(logic kind, logic [15:0] data);
         lpd_result_type got;
         lpd_result_type want;
         got.kind = kind;
         got.channel = data[4:0];
         got.payload_byte = data[12:5];
         got.status = data[14:13];
         if (expected_results.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected beat: kind %0d channel %0d byte %02x status %0d",
                        got.kind, got.channel, got.payload_byte, got.status);
            return;
         end
         want = expected_results.pop_front();
         if (got.kind != want.kind || got.channel != want.channel ||
             got.payload_byte != want.payload_byte || got.status != want.status) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected %0d/%0d/%02x/%0d got %0d/%0d/%02x/%0d",
                        want.kind, want.channel, want.payload_byte, want.status,
                        got.kind, got.channel, got.payload_byte, got.status);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we;
   logic        csr_addr;
   logic [EnableWidth-1:0] csr_wdata;

   frame_tracker tracker = new();
   bit          calm = 1'b0;
   bit          hold_off_wanted = 1'b0;
   int unsigned packet_beats = 0;
   int unsigned quiet_cycles = 0;
   int unsigned held_cycles = 0;

   link_packet_deframer #(.CHANNEL_COUNT(ChannelCount)) DUT (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void quiet_hold();
      held_cycles++;
      if (held_cycles == 300) begin
         hold_off_wanted = 1'b0;
         held_cycles = 0;
      end
   endfunction

   task automatic send_beat(input logic act, input logic [7:0] b);
      if (!calm)
         while ($urandom_range(99) < 16) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.absorb_beat(act, b);
   endtask

   task automatic send_packet(input logic [7:0] meta, input logic [15:0] frame_size,
                              input bit corrupt, input int cut);
      logic [7:0]  beats[$];
      logic [15:0] sum;
      logic [7:0]  b;
      int          n;
      sum = {8'h00, meta} + frame_size;
      beats = {tracker.start_value, meta, frame_size[7:0], frame_size[15:8]};
      for (int i = 0; i < int'(frame_size) && (cut < 0 || beats.size() < cut); i++) begin
         b = 8'($urandom_range(255));
         beats.push_back(b);
         sum = sum + {8'h00, b};
      end
      sum = ~sum;
      if (corrupt) sum = sum ^ 16'($urandom_range(65535, 1));
      beats.push_back(sum[7:0]);
      beats.push_back(sum[15:8]);
      n = (cut >= 0 && cut < beats.size()) ? cut : beats.size();
      for (int i = 0; i < n; i++) begin
         send_beat(ActionByte, beats[i]);
         packet_beats++;
      end
      if (n < beats.size()) begin
         send_beat(ActionTimeout, 8'($urandom_range(255)));
         packet_beats++;
      end
   endtask

   task automatic send_noise();
      logic [7:0] b;
      repeat ($urandom_range(3, 1)) begin
         b = 8'($urandom_range(255));
         if (b == tracker.start_value) b = ~b;
         if ($urandom_range(99) < 30) send_beat(ActionTimeout, b);
         else send_beat(ActionByte, b);
      end
   endtask

   task automatic send_random_frame();
      int          pick;
      logic [15:0] frame_size;
      int          cut;
      bit          corrupt;
      pick = $urandom_range(99);
      if (pick < 8) begin
         send_noise();
         return;
      end
      pick = $urandom_range(99);
      if (pick < 70) frame_size = 16'($urandom_range(6));
      else if (pick < 93) frame_size = 16'($urandom_range(24, 7));
      else frame_size = 16'($urandom_range(65535));
      corrupt = ($urandom_range(99) < 10);
      cut = -1;
      if (frame_size > 16'd24) cut = $urandom_range(12, 1);
      else if ($urandom_range(99) < 10) cut = $urandom_range(int'(frame_size) + 5, 1);
      send_packet(8'($urandom_range(255)), frame_size, corrupt, cut);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (tracker.expected_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic configure(input logic [7:0] start_value, input logic [31:0] mask);
      csr_we <= 1'b1;
      csr_addr <= CsrStartByte;
      csr_wdata <= {24'h000000, start_value};
      @(posedge clock);
      csr_addr <= CsrChannelEnable;
      csr_wdata <= mask;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.start_value = start_value;
      tracker.enable_mask = mask;
   endtask

   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) tracker.check_result(rsp_tuser, rsp_tdata);
         if (hold_off_wanted) begin
            rsp_tready <= 1'b0;
            quiet_hold();
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 16);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= ActionByte;
      csr_we <= 1'b0;
      csr_addr <= CsrStartByte;
      csr_wdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // hunt timeout, then timeout before metadata with channels off
      send_beat(ActionTimeout, 8'h00);
      send_beat(ActionByte, 8'hFF);
      send_beat(ActionByte, 8'h00);
      send_packet(8'h00, 16'd0, 1'b0, 1);
      settle();
      configure(StartByteReset, 32'hFFFF_FFFF);
      send_packet(8'hFF, 16'd0, 1'b0, -1);
      send_packet(8'hE0, 16'd1, 1'b1, -1);
      // drop channel 5 in the middle of its payload
      send_beat(ActionByte, StartByteReset);
      send_beat(ActionByte, 8'h05);
      send_beat(ActionByte, 8'h03);
      send_beat(ActionByte, 8'h00);
      send_beat(ActionByte, 8'h00);
      settle();
      configure(StartByteReset, 32'hFFFF_FFDF);
      send_beat(ActionByte, 8'hFF);
      send_beat(ActionByte, 8'h5A);
      send_beat(ActionByte, 8'h9E);
      send_beat(ActionByte, 8'hFE);

      packet_beats = 0;
      for (int ph = 0; ph < 8; ph++) begin
         settle();
         case (ph)
            0: configure(8'h00, 32'hFFFF_FFFF);
            1: configure(8'hFF, 32'h0000_0000);
            2: configure(StartByteReset, $urandom);
            3: configure(8'($urandom_range(255)), 32'hFFFF_FFFF);
            4: configure(8'($urandom_range(255)), $urandom);
            5: configure(8'($urandom_range(255)), 32'h8000_0009);
            6: configure(8'hFF, $urandom);
            default: configure(8'h00, 32'hFFFF_FFFF);
         endcase
         calm = (ph == 2);
         if (ph == 4) hold_off_wanted = 1'b1;
         if (ph == 5) send_packet(8'h03, 16'd260, 1'b0, -1);
         while (packet_beats < PhaseBeats * (ph + 1)) send_random_frame();
      end

      settle();
      repeat (4) @(posedge clock);
      if (tracker.errors == 0 && tracker.expected_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
